[sv/segx_pkg.sv]
`default_nettype none
package segx_pkg;

	localparam int COORD_W = 16;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int XPROD_W = PROD_W + 1;
	localparam int MAG_W = XPROD_W - 1;
	localparam int UMAG_W = COORD_W;
	localparam int SQSUM_W = 2 * UMAG_W + 1;
	localparam int FRAC_W = 16;
	localparam int DIST_W = COORD_W + 1;
	localparam int ROOT_STEPS = 17;
	localparam int ROOT_W = 34;

	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_HIT      = 2'd1,
		ST_PARALLEL = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] c_x;
		logic signed [COORD_W-1:0] c_y;
		logic signed [COORD_W-1:0] d_x;
		logic signed [COORD_W-1:0] d_y;
	} item_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [COORD_W-1:0] cross_x;
		logic signed [COORD_W-1:0] cross_y;
		logic [DIST_W-1:0]         distance;
	} result_t;

	// Common part of the point data carried down the pipeline.
	typedef struct packed {
		status_t              status;
		logic [COORD_W-1:0]   ax;
		logic [COORD_W-1:0]   ay;
		logic [UMAG_W-1:0]    ux;
		logic [UMAG_W-1:0]    uy;
		logic                 sx;
		logic                 sy;
	} carry_t;

	typedef struct packed {
		carry_t             c;
		logic [MAG_W-1:0]   rem;
		logic [MAG_W-1:0]   dvs;
		logic [ROOT_W-1:0]  n;
	} mid_t;

	typedef struct packed {
		carry_t             c;
		logic [MAG_W-1:0]   rem;
		logic [MAG_W-1:0]   dvs;
		logic [ROOT_W-1:0]  n;
		logic [ROOT_W-1:0]  res;
		logic [FRAC_W-1:0]  rq;
	} dsq_t;

	typedef struct packed {
		carry_t             c;
		logic [FRAC_W-1:0]  rq;
		logic [DIST_W-1:0]  len;
	} ratio_t;

	function automatic logic [MAG_W-1:0] mag(input logic signed [XPROD_W-1:0] x);
		logic signed [XPROD_W-1:0] nx;
		nx = -x;
		return x[XPROD_W-1] ? MAG_W'(nx) : MAG_W'(x);
	endfunction

	function automatic logic [UMAG_W-1:0] umag(input logic signed [DIFF_W-1:0] x);
		logic signed [DIFF_W-1:0] nx;
		nx = -x;
		return x[DIFF_W-1] ? UMAG_W'(nx) : UMAG_W'(x);
	endfunction

endpackage
`default_nettype wire

[sv/segx_front.sv]
`default_nettype none
module segx_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  segx_pkg::item_t     in_data,
	output logic                out_valid,
	output segx_pkg::mid_t      out_data
);

	localparam int DW = segx_pkg::DIFF_W;
	localparam int PW = segx_pkg::PROD_W;
	localparam int XW = segx_pkg::XPROD_W;

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [DW-1:0] abx_s1, aby_s1, cdx_s1, cdy_s1, acx_s1, acy_s1;
	logic [segx_pkg::COORD_W-1:0] ax_s1, ay_s1;

	logic signed [PW-1:0] p_rt1_s2, p_rt2_s2, p_st1_s2, p_st2_s2, p_dn1_s2, p_dn2_s2;
	logic [2*segx_pkg::UMAG_W-1:0] sqx_s2, sqy_s2;
	logic [segx_pkg::COORD_W-1:0] ax_s2, ay_s2;
	logic [segx_pkg::UMAG_W-1:0] ux_s2, uy_s2;
	logic sx_s2, sy_s2;

	logic signed [XW-1:0] rtop_s3, stop_s3, den_s3;
	logic [segx_pkg::SQSUM_W-1:0] sq_s3;
	logic [segx_pkg::COORD_W-1:0] ax_s3, ay_s3;
	logic [segx_pkg::UMAG_W-1:0] ux_s3, uy_s3;
	logic sx_s3, sy_s3;

	segx_pkg::mid_t mid_s4;

	logic [segx_pkg::MAG_W-1:0] rmag, smag, dmag;
	logic r_in, s_in;
	segx_pkg::status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abx_s1 <= DW'(in_data.b_x) - DW'(in_data.a_x);
			aby_s1 <= DW'(in_data.b_y) - DW'(in_data.a_y);
			cdx_s1 <= DW'(in_data.d_x) - DW'(in_data.c_x);
			cdy_s1 <= DW'(in_data.d_y) - DW'(in_data.c_y);
			acx_s1 <= DW'(in_data.a_x) - DW'(in_data.c_x);
			acy_s1 <= DW'(in_data.a_y) - DW'(in_data.c_y);
			ax_s1  <= in_data.a_x;
			ay_s1  <= in_data.a_y;

			p_rt1_s2 <= acy_s1 * cdx_s1;
			p_rt2_s2 <= acx_s1 * cdy_s1;
			p_st1_s2 <= acy_s1 * abx_s1;
			p_st2_s2 <= acx_s1 * aby_s1;
			p_dn1_s2 <= abx_s1 * cdy_s1;
			p_dn2_s2 <= aby_s1 * cdx_s1;
			sqx_s2 <= segx_pkg::umag(abx_s1) * segx_pkg::umag(abx_s1);
			sqy_s2 <= segx_pkg::umag(aby_s1) * segx_pkg::umag(aby_s1);
			ux_s2 <= segx_pkg::umag(abx_s1);
			uy_s2 <= segx_pkg::umag(aby_s1);
			sx_s2 <= abx_s1[DW-1];
			sy_s2 <= aby_s1[DW-1];
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;

			rtop_s3 <= XW'(p_rt1_s2) - XW'(p_rt2_s2);
			stop_s3 <= XW'(p_st1_s2) - XW'(p_st2_s2);
			den_s3  <= XW'(p_dn1_s2) - XW'(p_dn2_s2);
			sq_s3   <= segx_pkg::SQSUM_W'(sqx_s2) + segx_pkg::SQSUM_W'(sqy_s2);
			ux_s3 <= ux_s2;
			uy_s3 <= uy_s2;
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;

			mid_s4.c.status <= st;
			mid_s4.c.ax <= ax_s3;
			mid_s4.c.ay <= ay_s3;
			mid_s4.c.ux <= ux_s3;
			mid_s4.c.uy <= uy_s3;
			mid_s4.c.sx <= sx_s3;
			mid_s4.c.sy <= sy_s3;
			mid_s4.rem <= rmag;
			mid_s4.dvs <= dmag;
			mid_s4.n   <= segx_pkg::ROOT_W'(sq_s3);
		end
	end

	// The hit test works on the exact numerators, so rounding never decides it.
	always_comb begin
		rmag = segx_pkg::mag(rtop_s3);
		smag = segx_pkg::mag(stop_s3);
		dmag = segx_pkg::mag(den_s3);
		r_in = (rtop_s3 != '0) && (rtop_s3[XW-1] == den_s3[XW-1]) && (rmag < dmag);
		s_in = (stop_s3 != '0) && (stop_s3[XW-1] == den_s3[XW-1]) && (smag < dmag);
		if (den_s3 == '0) begin
			st = segx_pkg::ST_PARALLEL;
		end else if (r_in && s_in) begin
			st = segx_pkg::ST_HIT;
		end else begin
			st = segx_pkg::ST_NONE;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = mid_s4;

endmodule
`default_nettype wire

[sv/segx_divsqrt.sv]
`default_nettype none
module segx_divsqrt (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  segx_pkg::mid_t      in_data,
	output logic                out_valid,
	output segx_pkg::ratio_t    out_data
);

	localparam int NS = segx_pkg::ROOT_STEPS;
	localparam int MW = segx_pkg::MAG_W;
	localparam int RW = segx_pkg::ROOT_W;

	segx_pkg::dsq_t head;
	segx_pkg::dsq_t pipe_s [1:NS];
	logic           v_s    [1:NS];

	always_comb begin
		head.c   = in_data.c;
		head.rem = in_data.rem;
		head.dvs = in_data.dvs;
		head.n   = in_data.n;
		head.res = '0;
		head.rq  = '0;
	end

	// Each stage retires one root bit; the first FRAC_W stages also retire a quotient bit.
	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam logic [RW-1:0] RBIT = RW'(1) << (2 * (NS - 1 - k));
		segx_pkg::dsq_t cur;
		logic cur_v;
		segx_pkg::dsq_t nxt;
		logic [MW:0] rem2;
		logic [RW-1:0] trial;

		if (k == 0) begin : g_first
			assign cur   = head;
			assign cur_v = in_valid;
		end else begin : g_next
			assign cur   = pipe_s[k];
			assign cur_v = v_s[k];
		end

		always_comb begin
			nxt   = cur;
			rem2  = {cur.rem, 1'b0};
			trial = cur.res + RBIT;
			if (k < segx_pkg::FRAC_W) begin
				if (rem2 >= {1'b0, cur.dvs}) begin
					nxt.rem = MW'(rem2 - {1'b0, cur.dvs});
					nxt.rq  = {cur.rq[segx_pkg::FRAC_W-2:0], 1'b1};
				end else begin
					nxt.rem = MW'(rem2);
					nxt.rq  = {cur.rq[segx_pkg::FRAC_W-2:0], 1'b0};
				end
			end
			if (cur.n >= trial) begin
				nxt.n   = cur.n - trial;
				nxt.res = (cur.res >> 1) + RBIT;
			end else begin
				nxt.res = cur.res >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid     = v_s[NS];
	assign out_data.c    = pipe_s[NS].c;
	assign out_data.rq   = pipe_s[NS].rq;
	assign out_data.len  = segx_pkg::DIST_W'(pipe_s[NS].res);

endmodule
`default_nettype wire

[sv/segx_scale.sv]
`default_nettype none
module segx_scale (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  segx_pkg::ratio_t    in_data,
	output logic                out_valid,
	output segx_pkg::result_t   out_data
);

	localparam int CW = segx_pkg::COORD_W;
	localparam int FW = segx_pkg::FRAC_W;
	localparam int MXW = segx_pkg::UMAG_W + FW;
	localparam int DLW = segx_pkg::DIST_W + FW;
	localparam logic [MXW:0] HALF_M = (MXW + 1)'(1) << (FW - 1);
	localparam logic [DLW:0] HALF_D = (DLW + 1)'(1) << (FW - 1);

	logic v_s1, v_s2;
	segx_pkg::carry_t c_s1;
	logic [MXW-1:0] mx_s1, my_s1;
	logic [DLW-1:0] dl_s1;
	segx_pkg::result_t res_s2;

	logic [MXW:0] rx, ry;
	logic [DLW:0] rd;
	logic [CW-1:0] mx, my;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		rx = (MXW + 1)'(mx_s1) + HALF_M;
		ry = (MXW + 1)'(my_s1) + HALF_M;
		rd = (DLW + 1)'(dl_s1) + HALF_D;
		mx = rx[FW +: CW];
		my = ry[FW +: CW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= in_data.c;
			mx_s1 <= MXW'(in_data.c.ux) * MXW'(in_data.rq);
			my_s1 <= MXW'(in_data.c.uy) * MXW'(in_data.rq);
			dl_s1 <= DLW'(in_data.len) * DLW'(in_data.rq);

			res_s2.status <= c_s1.status;
			if (c_s1.status == segx_pkg::ST_HIT) begin
				res_s2.cross_x  <= c_s1.sx ? c_s1.ax - mx : c_s1.ax + mx;
				res_s2.cross_y  <= c_s1.sy ? c_s1.ay - my : c_s1.ay + my;
				res_s2.distance <= rd[FW +: segx_pkg::DIST_W];
			end else begin
				res_s2.cross_x  <= '0;
				res_s2.cross_y  <= '0;
				res_s2.distance <= '0;
			end
		end
	end

	assign out_valid = v_s2;
	assign out_data  = res_s2;

endmodule
`default_nettype wire

[sv/segment_intersection_2d_top.sv]
// Segment pair intersection, one pair per beat.
// Input channel: item_valid / item_stall with item carrying points A, B, C, D
// in signed Q12.4. Output channel: result_valid / result_stall with result
// carrying status (none, hit, parallel), the crossing point and the distance
// from A to it; point and distance are zero unless the status is a hit.
// From an accepted beat to its result there are 4 front stages (differences,
// products, cross products, hit test), 17 stages of the shared divide and
// square root chain (one root bit per stage, one quotient bit in all but the
// last) and 2 scaling stages whose last register drives the output.
// Throughput is one pair per cycle while the receiver takes results.
// The whole pipeline advances together; when a result waits under
// result_stall, every stage holds and item_stall is raised, so nothing is
// lost or repeated. Reset clears all valid bits and the block is empty and
// ready right after it.
`default_nettype none
module segment_intersection_2d_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_stall,
	input  segx_pkg::item_t     item,
	output logic                result_valid,
	input  wire logic           result_stall,
	output segx_pkg::result_t   result
);

	logic en;
	logic mid_valid, ratio_valid;
	segx_pkg::mid_t mid;
	segx_pkg::ratio_t ratio;

	assign en = !(result_valid && result_stall);
	assign item_stall = !en;

	segx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_valid),
		.in_data   (item),
		.out_valid (mid_valid),
		.out_data  (mid)
	);

	segx_divsqrt u_divsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mid_valid),
		.in_data   (mid),
		.out_valid (ratio_valid),
		.out_data  (ratio)
	);

	segx_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ratio_valid),
		.in_data   (ratio),
		.out_valid (result_valid),
		.out_data  (result)
	);

endmodule
`default_nettype wire
